FILE: hdl/mtf_pkg.sv
// Package for the move-to-front recency list: payload structs, codes and cell control.
// No dependencies; every other file in hdl/ imports it.
package mtf_pkg;

   localparam int KEY_FIELD_W   = 32;
   localparam int ROW_FIELD_W   = 4;
   localparam int COUNT_FIELD_W = 5;
   localparam int CAP_W         = 5;

   localparam logic [CAP_W-1:0] RESET_CAPACITY = 5'd15;

   typedef enum logic [1:0] {
      OP_TOUCH  = 2'd0,
      OP_FORGET = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_EMPTY_KEY = 2'd1,
      STATUS_BAD_ROW   = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]             op;
      logic [KEY_FIELD_W-1:0] key;
      logic [ROW_FIELD_W-1:0] row;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic                     hit;
      logic [ROW_FIELD_W-1:0]   hit_index;
      logic                     evicted;
      logic [KEY_FIELD_W-1:0]   evicted_key;
      logic [KEY_FIELD_W-1:0]   read_key;
      logic [COUNT_FIELD_W-1:0] entry_count;
   } rsp_type;

   // per-cell steering from the list control
   typedef struct packed {
      logic take_left;   // load the neighbour nearer the front (cell 0: the new key)
      logic take_right;  // load the neighbour further back (closes a gap)
      logic select;      // drive this cell's key onto the tap bus
   } cell_ctrl_type;

endpackage

FILE: hdl/mtf_cell.sv
// One list cell: a key register that compares against the search key and shifts
// to or from either neighbour. Depends on mtf_pkg.
module mtf_cell import mtf_pkg::*; #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic [KEY_WIDTH-1:0] right_key,
   input  logic [KEY_WIDTH-1:0] search_key,
   output logic [KEY_WIDTH-1:0] key_out,
   output logic                 match,
   output logic [KEY_WIDTH-1:0] tap_key
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   always_comb begin
      key_in = key_ff;
      if (ctrl.take_left) begin
         key_in = left_key;
      end else if (ctrl.take_right) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;
   assign match   = (key_ff == search_key);
   assign tap_key = ctrl.select ? key_ff : '0;

endmodule

FILE: hdl/mru_move_to_front_list_unit.sv
// Top level of the move-to-front recency list: control, cell chain and result register.
// Depends on mtf_pkg and mtf_cell.
//
// Keeps up to csr capacity keys in recency order (row 0 newest) in a chain of MAX_ENTRIES
// cells. At the transfer edge all cells compare their key with the request key at once,
// the list shifts by one place along the chain, and the result is captured in the output
// register, so one item per clock is sustained while results are taken. req_ready is high
// whenever the output register is empty or is being emptied in the same cycle; the compare,
// the hit encoder and the one-step shift are combinational ahead of the cell and output registers.
// Cells hold no reset; the fill count alone says which rows are live, so there is no
// clearing pass after reset. Capacity 0 behaves as 1 and values above MAX_ENTRIES as
// MAX_ENTRIES; lowering the capacity below the fill does not shrink the list, later new
// keys simply evict. Keys wider or narrower than 32 bits are zero-extended or truncated.
module mru_move_to_front_list_unit import mtf_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_WIDTH   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CMP_W = CNT_W + CAP_W;
   localparam logic [CNT_W-1:0] CNT_ONE = 1;
   localparam logic [CMP_W-1:0] CMP_ONE = 1;
   localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(MAX_ENTRIES);

   // registers
   logic [CNT_W-1:0] count_ff,     count_in;
   logic [CAP_W-1:0] cap_ff,       cap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff,  rsp_data_in;

   // cell chain
   logic [KEY_WIDTH-1:0] cell_key [MAX_ENTRIES];
   logic [KEY_WIDTH-1:0] cell_tap [MAX_ENTRIES];
   cell_ctrl_type        cell_ctrl [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_match;
   logic [MAX_ENTRIES-1:0] live_match;

   // request decode
   logic                        xfer;
   logic                        is_touch, is_forget, is_read;
   logic [KEY_WIDTH+KEY_FIELD_W-1:0] key_ext;
   logic [KEY_WIDTH-1:0]        search_key;
   logic                        key_empty;
   logic                        row_ok;
   logic [IDX_W+ROW_FIELD_W-1:0] row_ext;
   logic [IDX_W-1:0]            row_idx;
   logic [CMP_W-1:0]            cap_ext, eff_cap, count_cmp;
   logic                        full;
   logic [CNT_W-1:0]            count_dec;

   // list control
   logic                        any_hit;
   logic [IDX_W-1:0]            hit_idx;
   logic [IDX_W-1:0]            front_pos;
   logic [IDX_W-1:0]            sel_idx;
   logic                        touch_go, forget_go;
   logic [KEY_WIDTH-1:0]        tap_key;
   logic [KEY_WIDTH+KEY_FIELD_W-1:0] tap_ext;
   logic [IDX_W+ROW_FIELD_W-1:0] hit_ext;
   logic [CNT_W+COUNT_FIELD_W-1:0] count_out_ext;

   // output register decouples the two sides; drain and refill in the same cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign xfer      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_touch  = (req_data.op == OP_TOUCH);
   assign is_forget = (req_data.op == OP_FORGET);
   assign is_read   = (req_data.op == OP_READ);

   // key masked to the stored width; zero stands for the empty key
   assign key_ext    = {{KEY_WIDTH{1'b0}}, req_data.key};
   assign search_key = key_ext[KEY_WIDTH-1:0];
   assign key_empty  = (search_key == '0);

   assign row_ok  = ({{CNT_W{1'b0}}, req_data.row} < {{ROW_FIELD_W{1'b0}}, count_ff});
   assign row_ext = {{IDX_W{1'b0}}, req_data.row};
   assign row_idx = row_ext[IDX_W-1:0];   // only used when row_ok, so it fits

   // effective capacity, clamped to 1..MAX_ENTRIES
   always_comb begin
      cap_ext = {{CNT_W{1'b0}}, cap_ff};
      if (cap_ext == '0) begin
         eff_cap = CMP_ONE;
      end else if (cap_ext > CMP_MAX) begin
         eff_cap = CMP_MAX;
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign count_cmp = {{CAP_W{1'b0}}, count_ff};
   assign full      = (count_cmp >= eff_cap);
   assign count_dec = count_ff - CNT_ONE;

   assign touch_go  = xfer && is_touch && !key_empty;
   assign forget_go = xfer && is_forget && row_ok;

   // Live keys are unique, so at most one live cell matches and an OR of the
   // matching row numbers gives the hit position without a priority chain.
   always_comb begin
      tap_key = '0;
      hit_idx = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         tap_key = tap_key | cell_tap[i];
         if (live_match[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end
   assign any_hit = |live_match;

   // deepest row that moves up by one on a touch
   always_comb begin
      if (any_hit) begin
         front_pos = hit_idx;
      end else if (!full) begin
         front_pos = count_ff[IDX_W-1:0];     // below capacity, so below MAX_ENTRIES
      end else begin
         front_pos = count_dec[IDX_W-1:0];    // oldest row, overwritten
      end
   end

   // tap bus: read row, or the oldest row on a touch that evicts
   assign sel_idx = is_read ? row_idx : count_dec[IDX_W-1:0];

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic [KEY_WIDTH-1:0] right_key;

      if (g == 0) begin : g_head
         assign left_key = search_key;
      end else begin : g_body
         assign left_key = cell_key[g-1];
      end

      if (g == MAX_ENTRIES - 1) begin : g_tail
         assign right_key = '0;
      end else begin : g_inner
         assign right_key = cell_key[g+1];
      end

      assign cell_ctrl[g].take_left  = touch_go && (IDX_W'(g) <= front_pos);
      assign cell_ctrl[g].take_right = forget_go && (IDX_W'(g) >= row_idx);
      assign cell_ctrl[g].select     = (IDX_W'(g) == sel_idx);
      assign live_match[g]           = cell_match[g] && (CNT_W'(g) < count_ff);

      mtf_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .left_key   (left_key),
         .right_key  (right_key),
         .search_key (search_key),
         .key_out    (cell_key[g]),
         .match      (cell_match[g]),
         .tap_key    (cell_tap[g])
      );
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (touch_go && !any_hit && !full) begin
         count_in = count_ff + CNT_ONE;
      end else if (forget_go) begin
         count_in = count_dec;
      end
   end

   assign cap_in = csr_write_enable ? csr_write_data : cap_ff;

   // result assembly
   assign tap_ext       = {{KEY_FIELD_W{1'b0}}, tap_key};
   assign hit_ext       = {{ROW_FIELD_W{1'b0}}, hit_idx};
   assign count_out_ext = {{COUNT_FIELD_W{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in             = rsp_data_ff;
      if (xfer) begin
         rsp_data_in.status      = STATUS_DONE;
         rsp_data_in.hit         = 1'b0;
         rsp_data_in.hit_index   = '0;
         rsp_data_in.evicted     = 1'b0;
         rsp_data_in.evicted_key = '0;
         rsp_data_in.read_key    = '0;
         rsp_data_in.entry_count = count_out_ext[COUNT_FIELD_W-1:0];
         if (is_touch) begin
            if (key_empty) begin
               rsp_data_in.status = STATUS_EMPTY_KEY;
            end else if (any_hit) begin
               rsp_data_in.hit       = 1'b1;
               rsp_data_in.hit_index = hit_ext[ROW_FIELD_W-1:0];
            end else if (full) begin
               rsp_data_in.evicted     = 1'b1;
               rsp_data_in.evicted_key = tap_ext[KEY_FIELD_W-1:0];
            end
         end else if (is_forget || is_read) begin
            if (!row_ok) begin
               rsp_data_in.status = STATUS_BAD_ROW;
            end else if (is_read) begin
               rsp_data_in.read_key = tap_ext[KEY_FIELD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= RESET_CAPACITY;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hdl/mtf_checker.sv
// Port-level checks for the recency list top level, attached by bind.
// Depends on mtf_pkg and mru_move_to_front_list_unit.
module mtf_checker import mtf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // every transfer in shows a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("transfer in produced no result");

   // a hit never evicts and always completes
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> !rsp_data.evicted && rsp_data.status == STATUS_DONE)
      else $error("hit with eviction or error status");

   // stored keys are non-zero, so an evicted key is non-zero exactly when evicted
   a_evict_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.evicted == (rsp_data.evicted_key != '0)))
      else $error("evicted flag and key disagree");

   // ignored empty key leaves no other trace
   a_empty_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY_KEY |-> !rsp_data.hit && !rsp_data.evicted)
      else $error("empty key touched the list");

endmodule

bind mru_move_to_front_list_unit mtf_checker u_mtf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
